[hdl/diophantine_box_count_macros.svh]
// -----------------------------------------------------------------------------
// diophantine_box_count_macros
// Assertion macros shared by the block's modules; empty in synthesis.
// -----------------------------------------------------------------------------
`ifndef DIOPHANTINE_BOX_COUNT_MACROS_SVH
`define DIOPHANTINE_BOX_COUNT_MACROS_SVH

`ifndef SYNTHESIS
`define DBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DBC_ASSERT_IMP(lbl, ante, cons, msg)
`define DBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/dbc_pkg.sv]
// -----------------------------------------------------------------------------
// dbc_pkg
// Types, register names and the microprogram of the box counter.
// -----------------------------------------------------------------------------
package dbc_pkg;

	localparam int DW    = 64;
	localparam int RAW   = 5;
	localparam int NREG  = 32;
	localparam int PCW   = 8;
	localparam int IMMW  = 8;
	localparam int NIN   = 7;
	localparam int CNT_W = 63;
	localparam int GCD_W = 31;
	localparam int PX_W  = 63;

	typedef enum logic [3:0] {
		OP_LDI  = 4'd0,
		OP_LDIN = 4'd1,
		OP_ADD  = 4'd2,
		OP_SUB  = 4'd3,
		OP_MUL  = 4'd4,
		OP_DIV  = 4'd5,
		OP_MOVR = 4'd6,
		OP_OUT  = 4'd7,
		OP_BLT  = 4'd8,
		OP_BEQ  = 4'd9,
		OP_BNE  = 4'd10,
		OP_JMP  = 4'd11,
		OP_DONE = 4'd12
	} op_t;

	typedef logic [RAW-1:0] raddr_t;

	typedef struct packed {
		op_t              op;
		raddr_t           rd;
		raddr_t           rs1;
		raddr_t           rs2;
		logic [IMMW-1:0]  imm;
	} instr_t;

	typedef struct packed {
		logic   load_in;
		logic   rd_en;
		logic   exec;
		logic   wb_unit;
		instr_t ins;
	} cmd_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic unit_done;
	} status_t;

	// register file names
	localparam raddr_t R_Z    = 5'd0;
	localparam raddr_t R_ONE  = 5'd1;
	localparam raddr_t R_MONE = 5'd2;
	localparam raddr_t R_A    = 5'd3;
	localparam raddr_t R_B    = 5'd4;
	localparam raddr_t R_C    = 5'd5;
	localparam raddr_t R_LX   = 5'd6;
	localparam raddr_t R_RX   = 5'd7;
	localparam raddr_t R_LY   = 5'd8;
	localparam raddr_t R_RY   = 5'd9;
	localparam raddr_t R_P    = 5'd10;
	localparam raddr_t R_Q    = 5'd11;
	localparam raddr_t R_X0   = 5'd12;
	localparam raddr_t R_X1   = 5'd13;
	localparam raddr_t R_Y0   = 5'd14;
	localparam raddr_t R_Y1   = 5'd15;
	localparam raddr_t R_T    = 5'd16;
	localparam raddr_t R_U    = 5'd17;
	localparam raddr_t R_G    = 5'd18;
	localparam raddr_t R_PX   = 5'd19;
	localparam raddr_t R_PY   = 5'd20;
	localparam raddr_t R_AP   = 5'd21;
	localparam raddr_t R_BP   = 5'd22;
	localparam raddr_t R_X    = 5'd23;
	localparam raddr_t R_Y    = 5'd24;
	localparam raddr_t R_SA   = 5'd25;
	localparam raddr_t R_SB   = 5'd26;
	localparam raddr_t R_LX1  = 5'd27;
	localparam raddr_t R_RX1  = 5'd28;
	localparam raddr_t R_LX2  = 5'd29;
	localparam raddr_t R_RX2  = 5'd30;
	localparam raddr_t R_K    = 5'd31;

	// input field selects
	localparam logic [IMMW-1:0] I_A  = 8'd0;
	localparam logic [IMMW-1:0] I_B  = 8'd1;
	localparam logic [IMMW-1:0] I_C  = 8'd2;
	localparam logic [IMMW-1:0] I_LX = 8'd3;
	localparam logic [IMMW-1:0] I_RX = 8'd4;
	localparam logic [IMMW-1:0] I_LY = 8'd5;
	localparam logic [IMMW-1:0] I_RY = 8'd6;

	// result field selects
	localparam logic [IMMW-1:0] O_CNT  = 8'd0;
	localparam logic [IMMW-1:0] O_SOLV = 8'd1;
	localparam logic [IMMW-1:0] O_GCD  = 8'd2;
	localparam logic [IMMW-1:0] O_PX   = 8'd3;
	localparam logic [IMMW-1:0] O_PY   = 8'd4;

	// program labels
	localparam logic [PCW-1:0] L_NZ   = 8'd30;
	localparam logic [PCW-1:0] L_LOOP = 8'd40;
	localparam logic [PCW-1:0] L_EXB  = 8'd55;
	localparam logic [PCW-1:0] L_EXA  = 8'd59;
	localparam logic [PCW-1:0] L_GOT  = 8'd62;
	localparam logic [PCW-1:0] L_ANZ  = 8'd87;
	localparam logic [PCW-1:0] L_GEN  = 8'd95;
	localparam logic [PCW-1:0] L_END  = 8'd184;

	function automatic instr_t f_r(op_t op, raddr_t d, raddr_t a, raddr_t b);
		instr_t r;
		r.op = op; r.rd = d; r.rs1 = a; r.rs2 = b; r.imm = '0;
		return r;
	endfunction

	function automatic instr_t f_i(op_t op, raddr_t d, logic [IMMW-1:0] imm);
		instr_t r;
		r.op = op; r.rd = d; r.rs1 = R_Z; r.rs2 = R_Z; r.imm = imm;
		return r;
	endfunction

	function automatic instr_t f_o(logic [IMMW-1:0] sel, raddr_t s);
		instr_t r;
		r.op = OP_OUT; r.rd = R_Z; r.rs1 = s; r.rs2 = R_Z; r.imm = sel;
		return r;
	endfunction

	function automatic instr_t f_b(op_t op, raddr_t a, raddr_t b, logic [PCW-1:0] tgt);
		instr_t r;
		r.op = op; r.rd = R_Z; r.rs1 = a; r.rs2 = b; r.imm = tgt;
		return r;
	endfunction

	// microprogram: Euclid, scaling, clipping and counting
	function automatic instr_t rom(logic [PCW-1:0] pc);
		instr_t r;
		case (pc)
			8'd0:   r = f_i(OP_LDI, R_Z, 8'd0);
			8'd1:   r = f_i(OP_LDI, R_ONE, 8'd1);
			8'd2:   r = f_r(OP_SUB, R_MONE, R_Z, R_ONE);
			8'd3:   r = f_i(OP_LDIN, R_A, I_A);
			8'd4:   r = f_i(OP_LDIN, R_B, I_B);
			8'd5:   r = f_i(OP_LDIN, R_C, I_C);
			8'd6:   r = f_i(OP_LDIN, R_LX, I_LX);
			8'd7:   r = f_i(OP_LDIN, R_RX, I_RX);
			8'd8:   r = f_i(OP_LDIN, R_LY, I_LY);
			8'd9:   r = f_i(OP_LDIN, R_RY, I_RY);
			8'd10:  r = f_o(O_CNT, R_Z);
			8'd11:  r = f_o(O_SOLV, R_Z);
			8'd12:  r = f_o(O_GCD, R_Z);
			8'd13:  r = f_o(O_PX, R_Z);
			8'd14:  r = f_o(O_PY, R_Z);
			8'd15:  r = f_r(OP_ADD, R_PX, R_Z, R_Z);
			8'd16:  r = f_r(OP_ADD, R_PY, R_Z, R_Z);
			8'd17:  r = f_b(OP_BNE, R_A, R_Z, L_NZ);
			8'd18:  r = f_b(OP_BNE, R_B, R_Z, L_NZ);
			8'd19:  r = f_b(OP_BNE, R_C, R_Z, L_END);
			8'd20:  r = f_o(O_SOLV, R_ONE);
			8'd21:  r = f_b(OP_BLT, R_RX, R_LX, L_END);
			8'd22:  r = f_b(OP_BLT, R_RY, R_LY, L_END);
			8'd23:  r = f_r(OP_SUB, R_T, R_RX, R_LX);
			8'd24:  r = f_r(OP_ADD, R_T, R_T, R_ONE);
			8'd25:  r = f_r(OP_SUB, R_U, R_RY, R_LY);
			8'd26:  r = f_r(OP_ADD, R_U, R_U, R_ONE);
			8'd27:  r = f_r(OP_MUL, R_T, R_T, R_U);
			8'd28:  r = f_o(O_CNT, R_T);
			8'd29:  r = f_b(OP_JMP, R_Z, R_Z, L_END);
			8'd30:  r = f_r(OP_SUB, R_P, R_Z, R_A);
			8'd31:  r = f_b(OP_BLT, R_Z, R_P, 8'd33);
			8'd32:  r = f_r(OP_ADD, R_P, R_A, R_Z);
			8'd33:  r = f_r(OP_SUB, R_Q, R_Z, R_B);
			8'd34:  r = f_b(OP_BLT, R_Z, R_Q, 8'd36);
			8'd35:  r = f_r(OP_ADD, R_Q, R_B, R_Z);
			8'd36:  r = f_r(OP_ADD, R_X0, R_ONE, R_Z);
			8'd37:  r = f_r(OP_ADD, R_X1, R_Z, R_Z);
			8'd38:  r = f_r(OP_ADD, R_Y0, R_Z, R_Z);
			8'd39:  r = f_r(OP_ADD, R_Y1, R_ONE, R_Z);
			8'd40:  r = f_b(OP_BEQ, R_Q, R_Z, L_EXA);
			8'd41:  r = f_r(OP_DIV, R_T, R_P, R_Q);
			8'd42:  r = f_i(OP_MOVR, R_P, 8'd0);
			8'd43:  r = f_r(OP_MUL, R_U, R_T, R_X1);
			8'd44:  r = f_r(OP_SUB, R_X0, R_X0, R_U);
			8'd45:  r = f_r(OP_MUL, R_U, R_T, R_Y1);
			8'd46:  r = f_r(OP_SUB, R_Y0, R_Y0, R_U);
			8'd47:  r = f_b(OP_BEQ, R_P, R_Z, L_EXB);
			8'd48:  r = f_r(OP_DIV, R_T, R_Q, R_P);
			8'd49:  r = f_i(OP_MOVR, R_Q, 8'd0);
			8'd50:  r = f_r(OP_MUL, R_U, R_T, R_X0);
			8'd51:  r = f_r(OP_SUB, R_X1, R_X1, R_U);
			8'd52:  r = f_r(OP_MUL, R_U, R_T, R_Y0);
			8'd53:  r = f_r(OP_SUB, R_Y1, R_Y1, R_U);
			8'd54:  r = f_b(OP_JMP, R_Z, R_Z, L_LOOP);
			8'd55:  r = f_r(OP_ADD, R_G, R_Q, R_Z);
			8'd56:  r = f_r(OP_ADD, R_X, R_X1, R_Z);
			8'd57:  r = f_r(OP_ADD, R_Y, R_Y1, R_Z);
			8'd58:  r = f_b(OP_JMP, R_Z, R_Z, L_GOT);
			8'd59:  r = f_r(OP_ADD, R_G, R_P, R_Z);
			8'd60:  r = f_r(OP_ADD, R_X, R_X0, R_Z);
			8'd61:  r = f_r(OP_ADD, R_Y, R_Y0, R_Z);
			8'd62:  r = f_o(O_GCD, R_G);
			8'd63:  r = f_r(OP_DIV, R_T, R_C, R_G);
			8'd64:  r = f_i(OP_MOVR, R_U, 8'd0);
			8'd65:  r = f_b(OP_BNE, R_U, R_Z, L_END);
			8'd66:  r = f_o(O_SOLV, R_ONE);
			8'd67:  r = f_r(OP_MUL, R_PX, R_X, R_T);
			8'd68:  r = f_r(OP_MUL, R_PY, R_Y, R_T);
			8'd69:  r = f_b(OP_BLT, R_A, R_Z, 8'd71);
			8'd70:  r = f_b(OP_JMP, R_Z, R_Z, 8'd72);
			8'd71:  r = f_r(OP_SUB, R_PX, R_Z, R_PX);
			8'd72:  r = f_b(OP_BLT, R_B, R_Z, 8'd74);
			8'd73:  r = f_b(OP_JMP, R_Z, R_Z, 8'd75);
			8'd74:  r = f_r(OP_SUB, R_PY, R_Z, R_PY);
			8'd75:  r = f_o(O_PX, R_PX);
			8'd76:  r = f_o(O_PY, R_PY);
			8'd77:  r = f_b(OP_BLT, R_RX, R_LX, L_END);
			8'd78:  r = f_b(OP_BLT, R_RY, R_LY, L_END);
			8'd79:  r = f_b(OP_BNE, R_A, R_Z, L_ANZ);
			8'd80:  r = f_r(OP_DIV, R_T, R_C, R_B);
			8'd81:  r = f_b(OP_BLT, R_T, R_LY, L_END);
			8'd82:  r = f_b(OP_BLT, R_RY, R_T, L_END);
			8'd83:  r = f_r(OP_SUB, R_T, R_RX, R_LX);
			8'd84:  r = f_r(OP_ADD, R_T, R_T, R_ONE);
			8'd85:  r = f_o(O_CNT, R_T);
			8'd86:  r = f_b(OP_JMP, R_Z, R_Z, L_END);
			8'd87:  r = f_b(OP_BNE, R_B, R_Z, L_GEN);
			8'd88:  r = f_r(OP_DIV, R_T, R_C, R_A);
			8'd89:  r = f_b(OP_BLT, R_T, R_LX, L_END);
			8'd90:  r = f_b(OP_BLT, R_RX, R_T, L_END);
			8'd91:  r = f_r(OP_SUB, R_T, R_RY, R_LY);
			8'd92:  r = f_r(OP_ADD, R_T, R_T, R_ONE);
			8'd93:  r = f_o(O_CNT, R_T);
			8'd94:  r = f_b(OP_JMP, R_Z, R_Z, L_END);
			8'd95:  r = f_r(OP_DIV, R_AP, R_A, R_G);
			8'd96:  r = f_r(OP_DIV, R_BP, R_B, R_G);
			8'd97:  r = f_r(OP_ADD, R_X, R_PX, R_Z);
			8'd98:  r = f_r(OP_ADD, R_Y, R_PY, R_Z);
			8'd99:  r = f_r(OP_ADD, R_SA, R_ONE, R_Z);
			8'd100: r = f_b(OP_BLT, R_Z, R_AP, 8'd102);
			8'd101: r = f_r(OP_ADD, R_SA, R_MONE, R_Z);
			8'd102: r = f_r(OP_ADD, R_SB, R_ONE, R_Z);
			8'd103: r = f_b(OP_BLT, R_Z, R_BP, 8'd105);
			8'd104: r = f_r(OP_ADD, R_SB, R_MONE, R_Z);
			// clip to the low x bound
			8'd105: r = f_r(OP_SUB, R_T, R_LX, R_X);
			8'd106: r = f_r(OP_DIV, R_K, R_T, R_BP);
			8'd107: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd108: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd109: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd110: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd111: r = f_b(OP_BLT, R_X, R_LX, 8'd113);
			8'd112: r = f_b(OP_JMP, R_Z, R_Z, 8'd118);
			8'd113: r = f_r(OP_ADD, R_K, R_SB, R_Z);
			8'd114: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd115: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd116: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd117: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd118: r = f_b(OP_BLT, R_RX, R_X, L_END);
			8'd119: r = f_r(OP_ADD, R_LX1, R_X, R_Z);
			// clip to the high x bound
			8'd120: r = f_r(OP_SUB, R_T, R_RX, R_X);
			8'd121: r = f_r(OP_DIV, R_K, R_T, R_BP);
			8'd122: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd123: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd124: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd125: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd126: r = f_b(OP_BLT, R_RX, R_X, 8'd128);
			8'd127: r = f_b(OP_JMP, R_Z, R_Z, 8'd133);
			8'd128: r = f_r(OP_SUB, R_K, R_Z, R_SB);
			8'd129: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd130: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd131: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd132: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd133: r = f_r(OP_ADD, R_RX1, R_X, R_Z);
			// clip to the low y bound
			8'd134: r = f_r(OP_SUB, R_T, R_Y, R_LY);
			8'd135: r = f_r(OP_DIV, R_K, R_T, R_AP);
			8'd136: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd137: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd138: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd139: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd140: r = f_b(OP_BLT, R_Y, R_LY, 8'd142);
			8'd141: r = f_b(OP_JMP, R_Z, R_Z, 8'd147);
			8'd142: r = f_r(OP_SUB, R_K, R_Z, R_SA);
			8'd143: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd144: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd145: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd146: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd147: r = f_b(OP_BLT, R_RY, R_Y, L_END);
			8'd148: r = f_r(OP_ADD, R_LX2, R_X, R_Z);
			// clip to the high y bound
			8'd149: r = f_r(OP_SUB, R_T, R_Y, R_RY);
			8'd150: r = f_r(OP_DIV, R_K, R_T, R_AP);
			8'd151: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd152: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd153: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd154: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd155: r = f_b(OP_BLT, R_RY, R_Y, 8'd157);
			8'd156: r = f_b(OP_JMP, R_Z, R_Z, 8'd162);
			8'd157: r = f_r(OP_ADD, R_K, R_SA, R_Z);
			8'd158: r = f_r(OP_MUL, R_U, R_BP, R_K);
			8'd159: r = f_r(OP_ADD, R_X, R_X, R_U);
			8'd160: r = f_r(OP_MUL, R_U, R_AP, R_K);
			8'd161: r = f_r(OP_SUB, R_Y, R_Y, R_U);
			8'd162: r = f_r(OP_ADD, R_RX2, R_X, R_Z);
			// order the y-derived interval, then intersect
			8'd163: r = f_b(OP_BLT, R_RX2, R_LX2, 8'd165);
			8'd164: r = f_b(OP_JMP, R_Z, R_Z, 8'd168);
			8'd165: r = f_r(OP_ADD, R_T, R_LX2, R_Z);
			8'd166: r = f_r(OP_ADD, R_LX2, R_RX2, R_Z);
			8'd167: r = f_r(OP_ADD, R_RX2, R_T, R_Z);
			8'd168: r = f_r(OP_ADD, R_T, R_LX1, R_Z);
			8'd169: r = f_b(OP_BLT, R_LX1, R_LX2, 8'd171);
			8'd170: r = f_b(OP_JMP, R_Z, R_Z, 8'd172);
			8'd171: r = f_r(OP_ADD, R_T, R_LX2, R_Z);
			8'd172: r = f_r(OP_ADD, R_U, R_RX1, R_Z);
			8'd173: r = f_b(OP_BLT, R_RX2, R_RX1, 8'd175);
			8'd174: r = f_b(OP_JMP, R_Z, R_Z, 8'd176);
			8'd175: r = f_r(OP_ADD, R_U, R_RX2, R_Z);
			8'd176: r = f_b(OP_BLT, R_U, R_T, L_END);
			8'd177: r = f_r(OP_ADD, R_K, R_BP, R_Z);
			8'd178: r = f_b(OP_BLT, R_Z, R_BP, 8'd180);
			8'd179: r = f_r(OP_SUB, R_K, R_Z, R_BP);
			8'd180: r = f_r(OP_SUB, R_U, R_U, R_T);
			8'd181: r = f_r(OP_DIV, R_U, R_U, R_K);
			8'd182: r = f_r(OP_ADD, R_U, R_U, R_ONE);
			8'd183: r = f_o(O_CNT, R_U);
			default: r = f_b(OP_DONE, R_Z, R_Z, 8'd0);
		endcase
		return r;
	endfunction

endpackage

[hdl/dbc_mul.sv]
// -----------------------------------------------------------------------------
// dbc_mul
// Iterative multiplier: low 64 bits of the product, 16 multiplier bits a cycle.
// -----------------------------------------------------------------------------
module dbc_mul
	import dbc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          done,
	output logic [DW-1:0] prod
);

	localparam int CH     = 16;
	localparam int MSTEPS = DW / CH;
	localparam int MCW    = $clog2(MSTEPS);

	logic           busy_q;
	logic           done_q;
	logic [MCW-1:0] cnt_q;
	logic [DW-1:0]  mcand_q;
	logic [DW-1:0]  mplier_q;
	logic [DW-1:0]  acc_q;
	logic [DW+CH-1:0] part;

	assign part = mcand_q * mplier_q[CH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= MCW'(cnt_q + 1'b1);
				if (cnt_q == MCW'(MSTEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= a;
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_q + part[DW-1:0];
			mcand_q  <= mcand_q << CH;
			mplier_q <= mplier_q >> CH;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[hdl/dbc_div.sv]
// -----------------------------------------------------------------------------
// dbc_div
// Signed radix-4 restoring divider, truncating; a zero divisor gives zero.
// -----------------------------------------------------------------------------
module dbc_div
	import dbc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int DSTEPS = DW / 2;
	localparam int DCW    = $clog2(DSTEPS);

	logic           busy_q;
	logic           done_q;
	logic [DCW-1:0] cnt_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  quo_q;
	logic [DW-1:0]  den_q;
	logic           nneg_q;
	logic           qneg_q;
	logic           dzero_q;

	logic [DW:0]   r1, r1s, r2, r2s;
	logic          ge1, ge2;
	logic [DW-1:0] q1, q2;

	// two quotient bits a cycle
	always_comb begin
		r1  = {rem_q, quo_q[DW-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1s = ge1 ? r1 - {1'b0, den_q} : r1;
		q1  = {quo_q[DW-2:0], ge1};
		r2  = {r1s[DW-1:0], q1[DW-1]};
		ge2 = r2 >= {1'b0, den_q};
		r2s = ge2 ? r2 - {1'b0, den_q} : r2;
		q2  = {q1[DW-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= DCW'(cnt_q + 1'b1);
				if (cnt_q == DCW'(DSTEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			quo_q   <= num[DW-1] ? -num : num;
			den_q   <= den[DW-1] ? -den : den;
			nneg_q  <= num[DW-1];
			qneg_q  <= num[DW-1] ^ den[DW-1];
			dzero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= r2s[DW-1:0];
			quo_q <= q2;
		end
	end

	assign done = done_q;
	assign quo  = dzero_q ? '0 : (qneg_q ? -quo_q : quo_q);
	assign rem  = dzero_q ? '0 : (nneg_q ? -rem_q : rem_q);

endmodule

[hdl/dbc_ctrl.sv]
// -----------------------------------------------------------------------------
// dbc_ctrl
// Microprogram sequencer: fetch, execute, wait on the shared units.
// -----------------------------------------------------------------------------
`include "diophantine_box_count_macros.svh"

module dbc_ctrl
	import dbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_EXEC  = 4'b0100,
		S_WAIT  = 4'b1000
	} state_t;

	state_t         state_q;
	logic [PCW-1:0] pc_q;
	logic           done_q;
	instr_t         ins;
	logic [PCW-1:0] pc_inc;

	assign ins    = rom(pc_q);
	assign pc_inc = PCW'(pc_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pc_q    <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FETCH;
					pc_q    <= pc_inc;
					unique case (ins.op) inside
						OP_MUL, OP_DIV: begin
							state_q <= S_WAIT;
							pc_q    <= pc_q;
						end
						OP_DONE: begin
							state_q <= S_IDLE;
							pc_q    <= pc_q;
							done_q  <= 1'b1;
						end
						OP_BLT: if (status.lt) pc_q <= ins.imm;
						OP_BEQ: if (status.eq) pc_q <= ins.imm;
						OP_BNE: if (!status.eq) pc_q <= ins.imm;
						OP_JMP: pc_q <= ins.imm;
						default: ;
					endcase
				end
				S_WAIT: begin
					if (status.unit_done) begin
						pc_q    <= pc_inc;
						state_q <= S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load_in = (state_q == S_IDLE) && start;
		cmd.rd_en   = (state_q == S_FETCH);
		cmd.exec    = (state_q == S_EXEC);
		cmd.wb_unit = (state_q == S_WAIT);
		cmd.ins     = ins;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`DBC_ASSERT_IMP(a_done_in_idle, done_q, state_q == S_IDLE, "done outside idle")
	`DBC_ASSERT_NXT(a_start_fetch, (state_q == S_IDLE) && start,
		(state_q == S_FETCH) && (pc_q == '0), "start did not restart the program")

endmodule

[hdl/dbc_dpath.sv]
// -----------------------------------------------------------------------------
// dbc_dpath
// Register file, ALU, shared multiplier and divider, result registers.
// -----------------------------------------------------------------------------
`include "diophantine_box_count_macros.svh"

module dbc_dpath
	import dbc_pkg::*;
#(
	parameter int OPERAND_WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic [OPERAND_WIDTH-1:0] coef_a,
	input  logic [OPERAND_WIDTH-1:0] coef_b,
	input  logic [OPERAND_WIDTH-1:0] rhs_c,
	input  logic [OPERAND_WIDTH-1:0] x_low,
	input  logic [OPERAND_WIDTH-1:0] x_high,
	input  logic [OPERAND_WIDTH-1:0] y_low,
	input  logic [OPERAND_WIDTH-1:0] y_high,
	output logic [CNT_W-1:0]         solution_count,
	output logic                     solvable,
	output logic [GCD_W-1:0]         gcd_value,
	output logic [PX_W-1:0]          particular_x,
	output logic [PX_W-1:0]          particular_y
);

	function automatic logic [DW-1:0] sext(logic [OPERAND_WIDTH-1:0] v);
		return {{(DW - OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v};
	endfunction

	logic [DW-1:0]    rf [NREG];
	logic [DW-1:0]    rd1_q, rd2_q;
	logic [DW-1:0]    in_q [NIN];
	logic [DW-1:0]    in_sel;
	logic             we;
	logic [DW-1:0]    wd;
	logic             mul_done, div_done;
	logic [DW-1:0]    mul_res, div_quo, div_rem;
	logic [CNT_W-1:0] cnt_q;
	logic             solv_q;
	logic [GCD_W-1:0] gcd_q;
	logic [PX_W-1:0]  px_q, py_q;

	// capture the transaction's operands
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q[0] <= sext(coef_a);
			in_q[1] <= sext(coef_b);
			in_q[2] <= sext(rhs_c);
			in_q[3] <= sext(x_low);
			in_q[4] <= sext(x_high);
			in_q[5] <= sext(y_low);
			in_q[6] <= sext(y_high);
		end
	end

	always_comb begin
		case (cmd.ins.imm)
			I_A:     in_sel = in_q[0];
			I_B:     in_sel = in_q[1];
			I_C:     in_sel = in_q[2];
			I_LX:    in_sel = in_q[3];
			I_RX:    in_sel = in_q[4];
			I_LY:    in_sel = in_q[5];
			I_RY:    in_sel = in_q[6];
			default: in_sel = '0;
		endcase
	end

	// register file: two registered reads, one write
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd1_q <= rf[cmd.ins.rs1];
			rd2_q <= rf[cmd.ins.rs2];
		end
		if (we) begin
			rf[cmd.ins.rd] <= wd;
		end
	end

	always_comb begin
		we = 1'b0;
		wd = '0;
		if (cmd.exec) begin
			unique case (cmd.ins.op)
				OP_LDI: begin
					we = 1'b1;
					wd = DW'(cmd.ins.imm);
				end
				OP_LDIN: begin
					we = 1'b1;
					wd = in_sel;
				end
				OP_ADD: begin
					we = 1'b1;
					wd = rd1_q + rd2_q;
				end
				OP_SUB: begin
					we = 1'b1;
					wd = rd1_q - rd2_q;
				end
				OP_MOVR: begin
					we = 1'b1;
					wd = div_rem;
				end
				default: ;
			endcase
		end else if (cmd.wb_unit && (mul_done || div_done)) begin
			we = 1'b1;
			wd = mul_done ? mul_res : div_quo;
		end
	end

	dbc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exec && (cmd.ins.op == OP_MUL)),
		.a      (rd1_q),
		.b      (rd2_q),
		.done   (mul_done),
		.prod   (mul_res)
	);

	dbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exec && (cmd.ins.op == OP_DIV)),
		.num    (rd1_q),
		.den    (rd2_q),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		status.lt        = $signed(rd1_q) < $signed(rd2_q);
		status.eq        = (rd1_q == rd2_q);
		status.unit_done = mul_done || div_done;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec && (cmd.ins.op == OP_OUT)) begin
			case (cmd.ins.imm)
				O_CNT:   cnt_q  <= rd1_q[CNT_W-1:0];
				O_SOLV:  solv_q <= rd1_q[0];
				O_GCD:   gcd_q  <= rd1_q[GCD_W-1:0];
				O_PX:    px_q   <= rd1_q[PX_W-1:0];
				O_PY:    py_q   <= rd1_q[PX_W-1:0];
				default: ;
			endcase
		end
	end

	assign solution_count = cnt_q;
	assign solvable       = solv_q;
	assign gcd_value      = gcd_q;
	assign particular_x   = px_q;
	assign particular_y   = py_q;

	`DBC_ASSERT_IMP(a_one_unit, mul_done, !div_done, "both units finished together")
	`DBC_ASSERT_IMP(a_done_in_wait, mul_done || div_done, cmd.wb_unit,
		"unit finished while the sequencer was not waiting")

endmodule

[hdl/diophantine_box_count.sv]
// -----------------------------------------------------------------------------
// diophantine_box_count
// Counts integer points of a*x + b*y = c inside a box, via extended Euclid.
// -----------------------------------------------------------------------------
//
//  channel   signals                                   transfer
//  -------   ---------------------------------------   ------------------------
//  input     start, coef_a, coef_b, rhs_c, x_low,      start high, busy low
//            x_high, y_low, y_high
//  result    done, solution_count, solvable,           done high, one cycle
//            gcd_value, particular_x, particular_y
//
// One transaction is in flight at a time; busy stays high until its result.
// A transaction runs setup, the Euclid division steps (up to about 44 steps),
// scaling and clipping. Division micro-ops wait on the shared radix-4 divider
// (32 divider steps) and multiplies wait on the shared multiplier (4 multiplier
// steps); every other micro-op goes on without waiting.
// Reset clears the sequencer and unit control; no clearing pass is needed.
// Results are shown for exactly one cycle with done; the receiver cannot stall.
//
module diophantine_box_count
	import dbc_pkg::*;
#(
	parameter int OPERAND_WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OPERAND_WIDTH-1:0] coef_a,
	input  logic [OPERAND_WIDTH-1:0] coef_b,
	input  logic [OPERAND_WIDTH-1:0] rhs_c,
	input  logic [OPERAND_WIDTH-1:0] x_low,
	input  logic [OPERAND_WIDTH-1:0] x_high,
	input  logic [OPERAND_WIDTH-1:0] y_low,
	input  logic [OPERAND_WIDTH-1:0] y_high,
	output logic                     done,
	output logic [CNT_W-1:0]         solution_count,
	output logic                     solvable,
	output logic [GCD_W-1:0]         gcd_value,
	output logic [PX_W-1:0]          particular_x,
	output logic [PX_W-1:0]          particular_y
);

	cmd_t    cmd;
	status_t status;

	// sequencer: steps the microprogram, waits on the divider and multiplier
	dbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: holds operands, registers, units and the result fields
	dbc_dpath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.coef_a         (coef_a),
		.coef_b         (coef_b),
		.rhs_c          (rhs_c),
		.x_low          (x_low),
		.x_high         (x_high),
		.y_low          (y_low),
		.y_high         (y_high),
		.solution_count (solution_count),
		.solvable       (solvable),
		.gcd_value      (gcd_value),
		.particular_x   (particular_x),
		.particular_y   (particular_y)
	);

endmodule

[verif/diophantine_box_count_test.sv]
// -----------------------------------------------------------------------------
// diophantine_box_count_test
// Self-checking bench: random and directed equations checked against a model.
// -----------------------------------------------------------------------------
module diophantine_box_count_test;
	import dbc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OW          = 31;
	localparam int QUIET_LIMIT = 50000;
	localparam int MAX_REPORTS = 10;

	// one equation with its box, raw port values
	typedef struct {
		logic [OW-1:0] a, b, c, lx, rx, ly, ry;
	} equation_t;

	// one answer as the block shows it
	typedef struct {
		logic [CNT_W-1:0] count;
		logic             solv;
		logic [GCD_W-1:0] gcd;
		logic [PX_W-1:0]  px;
		logic [PX_W-1:0]  py;
	} answer_t;

	logic clk, arst_n, start, busy, done;
	logic [OW-1:0] coef_a, coef_b, rhs_c, x_low, x_high, y_low, y_high;
	logic [CNT_W-1:0] solution_count;
	logic             solvable;
	logic [GCD_W-1:0] gcd_value;
	logic [PX_W-1:0]  particular_x, particular_y;

	answer_t pending_answers[$];
	int      gap_pct;
	int      sent_count, checked_count, mismatch_count, quiet_cycles;

	diophantine_box_count #(.OPERAND_WIDTH(OW)) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction: 64-bit wrapping arithmetic, divisions truncate toward zero
	// ---------------------------------------------------------------------
	function automatic longint quot(longint n, longint d);
		if (d == 0)
			return 0;
		if (d == -1)
			return -n;
		return n / d;
	endfunction

	function automatic longint remn(longint n, longint d);
		if (d == 0 || d == -1)
			return 0;
		return n % d;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint widen(logic [OW-1:0] v);
		return longint'($signed(v));
	endfunction

	// move the point k steps of (bp, -ap) along the line
	function automatic void step_along(inout longint x, inout longint y,
			input longint ap, input longint bp, input longint k);
		x = x + bp * k;
		y = y - ap * k;
	endfunction

	function automatic longint count_on_line(longint x, longint y, longint ap, longint bp,
			longint lx, longint rx, longint ly, longint ry);
		longint sa, sb, lo1, hi1, lo2, hi2, lo, hi, t;
		sa = (ap > 0) ? 1 : -1;
		sb = (bp > 0) ? 1 : -1;
		// clip to the x range
		step_along(x, y, ap, bp, quot(lx - x, bp));
		if (x < lx)
			step_along(x, y, ap, bp, sb);
		if (x > rx)
			return 0;
		lo1 = x;
		step_along(x, y, ap, bp, quot(rx - x, bp));
		if (x > rx)
			step_along(x, y, ap, bp, -sb);
		hi1 = x;
		// clip to the y range
		step_along(x, y, ap, bp, quot(y - ly, ap));
		if (y < ly)
			step_along(x, y, ap, bp, -sa);
		if (y > ry)
			return 0;
		lo2 = x;
		step_along(x, y, ap, bp, quot(y - ry, ap));
		if (y > ry)
			step_along(x, y, ap, bp, sa);
		hi2 = x;
		if (lo2 > hi2) begin
			t = lo2; lo2 = hi2; hi2 = t;
		end
		lo = (lo1 > lo2) ? lo1 : lo2;
		hi = (hi1 < hi2) ? hi1 : hi2;
		if (lo > hi)
			return 0;
		return quot(hi - lo, mag(bp)) + 1;
	endfunction

	function automatic answer_t solve_equation(equation_t e);
		longint a, b, c, lx, rx, ly, ry;
		longint p, q, t, r, x0, x1, y0, y1, nx, ny, g, px, py, cnt;
		logic   ok;
		answer_t ans;
		a = widen(e.a); b = widen(e.b); c = widen(e.c);
		lx = widen(e.lx); rx = widen(e.rx); ly = widen(e.ly); ry = widen(e.ry);
		g = 0; px = 0; py = 0; cnt = 0;
		if (a == 0 && b == 0) begin
			ok = (c == 0);
		end else begin
			// extended Euclid on the magnitudes
			p = mag(a); q = mag(b);
			x0 = 1; x1 = 0; y0 = 0; y1 = 1;
			while (q != 0) begin
				t  = quot(p, q);
				r  = p - t * q;
				nx = x0 - t * x1;
				ny = y0 - t * y1;
				p = q; q = r;
				x0 = x1; x1 = nx;
				y0 = y1; y1 = ny;
			end
			g  = p;
			ok = (remn(c, g) == 0);
			if (ok) begin
				px = x0 * quot(c, g);
				py = y0 * quot(c, g);
				if (a < 0) px = -px;
				if (b < 0) py = -py;
			end
		end
		if (lx > rx || ly > ry)
			cnt = 0;
		else if (a == 0 && b == 0)
			cnt = (c == 0) ? (rx - lx + 1) * (ry - ly + 1) : 0;
		else if (!ok)
			cnt = 0;
		else if (a == 0)
			cnt = (ly <= quot(c, b) && quot(c, b) <= ry) ? rx - lx + 1 : 0;
		else if (b == 0)
			cnt = (lx <= quot(c, a) && quot(c, a) <= rx) ? ry - ly + 1 : 0;
		else
			cnt = count_on_line(px, py, quot(a, g), quot(b, g), lx, rx, ly, ry);
		ans.count = cnt[CNT_W-1:0];
		ans.solv  = ok;
		ans.gcd   = g[GCD_W-1:0];
		ans.px    = px[PX_W-1:0];
		ans.py    = py[PX_W-1:0];
		return ans;
	endfunction

	// ---------------------------------------------------------------------
	// Result checker: every done pulse is matched against the oldest answer
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("[%0t] result with no transaction outstanding", $realtime);
			end else begin
				want = pending_answers.pop_front();
				checked_count++;
				if (want.count !== solution_count || want.solv !== solvable ||
						want.gcd !== gcd_value || want.px !== particular_x ||
						want.py !== particular_y) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("[%0t] mismatch on result %0d", $realtime, checked_count);
						$display("  count exp %0d got %0d, solvable exp %0b got %0b",
							want.count, solution_count, want.solv, solvable);
						$display("  gcd exp %0d got %0d", want.gcd, gcd_value);
						$display("  px exp %0d got %0d, py exp %0d got %0d",
							$signed(want.px), $signed(particular_x),
							$signed(want.py), $signed(particular_y));
					end
				end
			end
		end
	end

	// Watchdog: count cycles where neither channel moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_answers.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Present one equation; hold start until the block takes it.
	task automatic send_equation(equation_t e);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		coef_a <= e.a; coef_b <= e.b; rhs_c <= e.c;
		x_low  <= e.lx; x_high <= e.rx; y_low <= e.ly; y_high <= e.ry;
		do
			@(posedge clk);
		while (busy);
		pending_answers.push_back(solve_equation(e));
		sent_count++;
	endtask

	function automatic equation_t make_equation(longint a, longint b, longint c,
			longint lx, longint rx, longint ly, longint ry);
		equation_t e;
		e.a = a[OW-1:0]; e.b = b[OW-1:0]; e.c = c[OW-1:0];
		e.lx = lx[OW-1:0]; e.rx = rx[OW-1:0]; e.ly = ly[OW-1:0]; e.ry = ry[OW-1:0];
		return e;
	endfunction

	function automatic longint pick(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	localparam longint FMIN = -(longint'(1) <<< (OW - 1));
	localparam longint FMAX = (longint'(1) <<< (OW - 1)) - 1;

	// Special cases: empty box, degenerate coefficients, no solution
	task automatic test_special_cases();
		send_equation(make_equation(3, 5, 7, 10, 9, 0, 100));    // x range empty
		send_equation(make_equation(3, 5, 7, 0, 100, 4, -4));    // y range empty
		send_equation(make_equation(0, 0, 0, -3, 4, 2, 9));      // whole box
		send_equation(make_equation(0, 0, 0, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(0, 0, 6, -3, 4, 2, 9));      // never satisfied
		send_equation(make_equation(4, 6, 7, -100, 100, -100, 100)); // gcd misses c
		send_equation(make_equation(0, 7, 21, -5, 5, 0, 10));    // horizontal, hit
		send_equation(make_equation(0, -7, 21, -5, 5, 0, 10));   // horizontal, miss
		send_equation(make_equation(-9, 0, 27, -5, 5, 0, 10));   // vertical, hit
		send_equation(make_equation(9, 0, 270, -5, 5, 0, 10));   // vertical, miss
		send_equation(make_equation(2, 3, 12, -50, 50, -50, 50));
		send_equation(make_equation(-2, 3, -12, -50, 50, -50, 50));
		send_equation(make_equation(2, -3, 12, -50, 50, -50, 50));
		send_equation(make_equation(-2, -3, 12, 0, 0, -4, -4));  // one point
	endtask

	// Field extremes and the longest Euclid chains
	task automatic test_extremes();
		send_equation(make_equation(FMIN, FMIN, FMIN, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(1, -1, 0, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(-1, -1, FMIN, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(FMAX, FMIN, FMAX, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(701408733, 433494437, FMAX, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(-433494437, 701408733, FMIN, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(FMAX, 1, FMIN, FMIN, FMAX, FMIN, FMAX));
		send_equation(make_equation(FMIN, 0, FMIN, FMIN, FMAX, FMAX, FMAX));
		send_equation(make_equation(0, FMAX, FMAX, FMAX, FMAX, FMIN, FMAX));
	endtask

	// Mostly lines built through a known point, with a share of noise
	task automatic test_random_equations(int n_items);
		equation_t e;
		longint a, b, x0, y0;
		int     kind;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				a  = pick((kind < 30) ? 30 : 1000);
				b  = pick((kind < 30) ? 30 : 1000);
				x0 = pick(100000);
				y0 = pick(100000);
				e  = make_equation(a, b, a * x0 + b * y0,
					x0 - pick(2000), x0 + pick(2000), y0 - pick(2000), y0 + pick(2000));
			end else if (kind < 70) begin
				a  = ($urandom_range(0, 1)) ? 0 : pick(50);
				b  = (a != 0 && $urandom_range(0, 1)) ? 0 : pick(50);
				x0 = pick(500);
				e  = make_equation(a, b, (a + b) * x0 + pick(3),
					-pick(600) - 1, pick(600), -pick(600) - 1, pick(600));
			end else if (kind < 85) begin
				a  = longint'($signed($urandom_range(0, 65535) << 15)) >>> 1;
				b  = longint'($signed($urandom_range(0, 65535) << 15)) >>> 1;
				e  = make_equation(a, b, pick(1 << 29),
					-pick(1 << 29) - 1, pick(1 << 29), -pick(1 << 29) - 1, pick(1 << 29));
			end else begin
				e.a  = OW'($urandom); e.b  = OW'($urandom); e.c  = OW'($urandom);
				e.lx = OW'($urandom); e.rx = OW'($urandom);
				e.ly = OW'($urandom); e.ry = OW'($urandom);
			end
			send_equation(e);
		end
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		coef_a = '0; coef_b = '0; rhs_c = '0;
		x_low  = '0; x_high = '0; y_low = '0; y_high = '0;
		gap_pct = 25;
		sent_count = 0; checked_count = 0; mismatch_count = 0; quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_extremes();
		gap_pct = 25;
		test_random_equations(100);
		gap_pct = 67;
		test_random_equations(100);
		gap_pct = 0;
		test_random_equations(100);
		start <= 1'b0;

		// drain: the watchdog bounds this wait
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d equations (special cases, extremes, random lines and noise)",
			sent_count);
		$display("Checked %0d results, %0d mismatches", checked_count, mismatch_count);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/dbc_pkg.sv
hdl/dbc_mul.sv
hdl/dbc_div.sv
hdl/dbc_ctrl.sv
hdl/dbc_dpath.sv
hdl/diophantine_box_count.sv
verif/diophantine_box_count_test.sv
